// ===== design/ptmi_pkg.sv =====
// ptmi_pkg: shared constants and sequencer state type for the page table map insert block.
// No dependencies; used by page_table_map_insert.
package ptmi_pkg;

    // Default sizes of the table pool
    localparam int TABLE_COUNT_DEF = 64;
    localparam int ROOT_TABLES_DEF = 4;

    // Fixed table geometry: 512 entries of 64 bits, 4 KiB pages
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IX_W              = 9;
    localparam int PAGE_SHIFT        = 12;
    localparam int FLAG_W            = 12;
    localparam int PA_W              = 52;
    localparam int VA_W              = 48;
    localparam int PFN_W             = PA_W - PAGE_SHIFT;   // 40
    localparam int VPN_W             = VA_W - PAGE_SHIFT;   // 36
    localparam int ENTRY_W           = 64;

    // Last intermediate level and the leaf level
    localparam logic [1:0] LVL_LAST_MID = 2'd2;
    localparam logic [1:0] LVL_LEAF     = 2'd3;

    // Configuration register indexes (paddr bit 3)
    localparam logic REG_ROOT_TABLE = 1'b0;
    localparam logic REG_POOL_BASE  = 1'b1;

    // Result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_CHK   = 7'b0001000,
        S_ACLR  = 7'b0010000,
        S_AWR   = 7'b0100000,
        S_LEAF  = 7'b1000000
    } t_state;

endpackage

// ===== design/page_table_map_insert.sv =====
// page_table_map_insert: four-level page table walker with bump allocation of new tables.
// Depends on ptmi_pkg for geometry constants and the sequencer state type.
//
// Usage: raise start with the virtual address, physical address and flags while busy is
// low; the word is taken at that edge and busy rises. The block walks the root table chosen
// by root_table and two intermediate levels in its single-port table memory, then writes
// the leaf. One result word (status, tables_added, leaf_value) appears for one cycle marked
// by o_done, in the cycle busy falls; a new word may be started in that same cycle.
// Without allocation the walk spends a read state and a check state on each level above the
// leaf, then writes the leaf. Each allocation adds a sweep of the new table to zero through
// the memory port and a write of the parent entry. The single memory port is why these
// steps run one after another. An error ends the walk early.
// After reset the block clears the whole table memory, all TABLE_COUNT * 512 entries,
// with busy high; the APB registers may be written meanwhile.
// The receiver cannot stall: each result is marked by o_done for exactly one cycle.
// APB: root_table at byte address 0, pool_base at 8; writes take setup and access cycles,
// pready is always high.
module page_table_map_insert #(
    parameter int TABLE_COUNT = ptmi_pkg::TABLE_COUNT_DEF,
    parameter int ROOT_TABLES = ptmi_pkg::ROOT_TABLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  logic [ptmi_pkg::VA_W-1:0]       i_va,
    input  logic [ptmi_pkg::PA_W-1:0]       i_pa,
    input  logic [ptmi_pkg::FLAG_W-1:0]     i_flags,
    // result channel
    output logic                            o_done,
    output logic                            o_status,
    output logic [1:0]                      o_tables_added,
    output logic [ptmi_pkg::ENTRY_W-1:0]    o_leaf_value,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);

    localparam int TW    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int NW    = $clog2(TABLE_COUNT + 1);
    localparam int AW    = TW + ptmi_pkg::IX_W;
    localparam int DEPTH = TABLE_COUNT * ptmi_pkg::ENTRIES_PER_TABLE;
    localparam int PFN_W = ptmi_pkg::PFN_W;

    // control state
    ptmi_pkg::t_state                r_state, n_state;
    logic [AW-1:0]                   r_cnt, n_cnt;
    logic [1:0]                      r_lvl, n_lvl;
    logic [TW-1:0]                   r_cur, n_cur;
    logic [1:0]                      r_added, n_added;
    logic [NW-1:0]                   r_next_free, n_next_free;
    logic [1:0]                      r_root;
    logic [ptmi_pkg::PA_W-1:0]       r_pool_base;
    logic                            r_done, n_done;

    // payload
    logic [ptmi_pkg::VPN_W-1:0]      r_vpn;
    logic [ptmi_pkg::PA_W-1:0]       r_pa;
    logic [ptmi_pkg::FLAG_W-1:0]     r_fl;
    logic                            r_status, n_status;
    logic [1:0]                      r_added_o, n_added_o;
    logic [ptmi_pkg::ENTRY_W-1:0]    r_leaf, n_leaf;

    // table memory
    logic [ptmi_pkg::ENTRY_W-1:0]    r_mem [DEPTH];
    logic [ptmi_pkg::ENTRY_W-1:0]    r_rdata;
    logic [AW-1:0]                   w_addr;
    logic [ptmi_pkg::ENTRY_W-1:0]    w_wdata;
    logic                            w_we;

    // shared address unit
    logic [PFN_W-1:0]                w_add_a, w_add_b, w_sum;
    logic                            w_add_c;

    logic [ptmi_pkg::IX_W-1:0]       w_ix;
    logic [TW-1:0]                   w_root_clamped;
    logic [ptmi_pkg::ENTRY_W-1:0]    w_leaf_val;
    logic                            w_cfg_wr;
    logic                            w_accept;

    assign w_accept = start && (r_state == ptmi_pkg::S_IDLE);
    assign w_cfg_wr = psel && penable && pwrite;

    // pick the entry index for the current level
    always_comb begin
        case (r_lvl)
            2'd0:    w_ix = r_vpn[35:27];
            2'd1:    w_ix = r_vpn[26:18];
            2'd2:    w_ix = r_vpn[17:9];
            default: w_ix = r_vpn[8:0];
        endcase
    end

    assign w_root_clamped = (32'(r_root) >= 32'(ROOT_TABLES)) ? TW'(ROOT_TABLES - 1)
                                                             : TW'(r_root);

    assign w_leaf_val = {{(ptmi_pkg::ENTRY_W - ptmi_pkg::PA_W){1'b0}},
                         r_pa[ptmi_pkg::PA_W-1:ptmi_pkg::FLAG_W],
                         r_pa[ptmi_pkg::FLAG_W-1:0] | r_fl};

    // one 40-bit adder: table base for allocation, pointer offset otherwise
    always_comb begin
        if (r_state == ptmi_pkg::S_AWR) begin
            w_add_a = r_pool_base[ptmi_pkg::PA_W-1:ptmi_pkg::PAGE_SHIFT];
            w_add_b = PFN_W'(r_next_free);
            w_add_c = 1'b0;
        end else begin
            w_add_a = r_rdata[ptmi_pkg::PA_W-1:ptmi_pkg::PAGE_SHIFT];
            w_add_b = ~r_pool_base[ptmi_pkg::PA_W-1:ptmi_pkg::PAGE_SHIFT];
            w_add_c = 1'b1;
        end
    end
    assign w_sum = w_add_a + w_add_b + PFN_W'(w_add_c);

    // memory port: address, data and enable per state
    always_comb begin
        w_addr  = {r_cur, w_ix};
        w_wdata = '0;
        w_we    = 1'b0;
        case (r_state)
            ptmi_pkg::S_CLEAR: begin
                w_addr = r_cnt;
                w_we   = 1'b1;
            end
            ptmi_pkg::S_ACLR: begin
                w_addr = {r_next_free[TW-1:0], r_cnt[ptmi_pkg::IX_W-1:0]};
                w_we   = 1'b1;
            end
            ptmi_pkg::S_AWR: begin
                w_wdata = {{(ptmi_pkg::ENTRY_W - ptmi_pkg::PA_W){1'b0}}, w_sum, r_fl};
                w_we    = 1'b1;
            end
            ptmi_pkg::S_LEAF: begin
                w_wdata = w_leaf_val;
                w_we    = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_lvl       = r_lvl;
        n_cur       = r_cur;
        n_added     = r_added;
        n_next_free = r_next_free;
        n_done      = 1'b0;
        n_status    = r_status;
        n_added_o   = r_added_o;
        n_leaf      = r_leaf;
        case (r_state)
            ptmi_pkg::S_CLEAR: begin
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_state = ptmi_pkg::S_IDLE;
                end
            end
            ptmi_pkg::S_IDLE: begin
                if (start) begin
                    n_cur   = w_root_clamped;
                    n_lvl   = 2'd0;
                    n_added = 2'd0;
                    n_state = ptmi_pkg::S_RD;
                end
            end
            ptmi_pkg::S_RD: begin
                n_state = ptmi_pkg::S_CHK;
            end
            ptmi_pkg::S_CHK: begin
                if (!r_rdata[0]) begin
                    if (r_next_free >= NW'(TABLE_COUNT)) begin
                        // pool exhausted: drop the walk
                        n_done    = 1'b1;
                        n_status  = ptmi_pkg::STATUS_ERROR;
                        n_added_o = r_added;
                        n_leaf    = '0;
                        n_state   = ptmi_pkg::S_IDLE;
                    end else begin
                        n_cnt   = '0;
                        n_state = ptmi_pkg::S_ACLR;
                    end
                end else if (w_sum >= PFN_W'(TABLE_COUNT)) begin
                    // pointer outside the pool
                    n_done    = 1'b1;
                    n_status  = ptmi_pkg::STATUS_ERROR;
                    n_added_o = r_added;
                    n_leaf    = '0;
                    n_state   = ptmi_pkg::S_IDLE;
                end else begin
                    n_cur = w_sum[TW-1:0];
                    n_lvl = r_lvl + 2'd1;
                    n_state = (r_lvl == ptmi_pkg::LVL_LAST_MID) ? ptmi_pkg::S_LEAF
                                                                : ptmi_pkg::S_RD;
                end
            end
            ptmi_pkg::S_ACLR: begin
                n_cnt = r_cnt + AW'(1);
                // last entry of the new table swept
                if (&r_cnt[ptmi_pkg::IX_W-1:0]) begin
                    n_state = ptmi_pkg::S_AWR;
                end
            end
            ptmi_pkg::S_AWR: begin
                n_cur       = r_next_free[TW-1:0];
                n_next_free = r_next_free + NW'(1);
                n_added     = r_added + 2'd1;
                n_lvl       = r_lvl + 2'd1;
                n_state = (r_lvl == ptmi_pkg::LVL_LAST_MID) ? ptmi_pkg::S_LEAF
                                                            : ptmi_pkg::S_RD;
            end
            ptmi_pkg::S_LEAF: begin
                n_done    = 1'b1;
                n_status  = ptmi_pkg::STATUS_OK;
                n_added_o = r_added;
                n_leaf    = w_leaf_val;
                n_state   = ptmi_pkg::S_IDLE;
            end
            default: begin
                n_state = ptmi_pkg::S_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptmi_pkg::S_CLEAR;
            r_cnt       <= '0;
            r_lvl       <= 2'd0;
            r_cur       <= '0;
            r_added     <= 2'd0;
            r_next_free <= NW'(ROOT_TABLES);
            r_done      <= 1'b0;
            r_root      <= 2'd0;
            r_pool_base <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_lvl       <= n_lvl;
            r_cur       <= n_cur;
            r_added     <= n_added;
            r_next_free <= n_next_free;
            r_done      <= n_done;
            if (w_cfg_wr) begin
                if (paddr[3] == ptmi_pkg::REG_ROOT_TABLE) begin
                    r_root <= pwdata[1:0];
                end else begin
                    r_pool_base <= pwdata[ptmi_pkg::PA_W-1:0];
                end
            end
        end
    end

    // hold the request word and the result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vpn <= i_va[ptmi_pkg::VA_W-1:ptmi_pkg::PAGE_SHIFT];
            r_pa  <= i_pa;
            r_fl  <= i_flags;
        end
        r_status  <= n_status;
        r_added_o <= n_added_o;
        r_leaf    <= n_leaf;
    end

    // table memory, read data registered
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    assign busy           = (r_state != ptmi_pkg::S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_tables_added = r_added_o;
    assign o_leaf_value   = r_leaf;
    assign pready         = 1'b1;
    assign prdata = (paddr[3] == ptmi_pkg::REG_POOL_BASE)
                  ? {{(64 - ptmi_pkg::PA_W){1'b0}}, r_pool_base}
                  : {62'd0, r_root};

    // an accepted word starts a walk
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start a walk");

    // a result only shows once the walk is over
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while walk still running");

    // a failed walk reports no leaf
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_leaf_value == '0))
        else $error("error result carries a leaf value");

    // allocator never runs past the pool
    a_nf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free <= NW'(TABLE_COUNT)))
        else $error("next free table beyond pool");

    // an allocation write only happens with a table in hand
    a_alloc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptmi_pkg::S_AWR) |-> (r_next_free < NW'(TABLE_COUNT)))
        else $error("parent entry written with pool exhausted");

endmodule

// ===== test/tb_page_table_map_insert.sv =====
// tb_page_table_map_insert: self-checking testbench for the page table map insert block.
// Depends on ptmi_pkg and page_table_map_insert; a scoreboard class mirrors the table store.
module tb_page_table_map_insert;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_COUNT       = ptmi_pkg::TABLE_COUNT_DEF;
    localparam int          ROOT_TABLES       = ptmi_pkg::ROOT_TABLES_DEF;
    localparam int          ENTRIES_PER_TABLE = ptmi_pkg::ENTRIES_PER_TABLE;
    localparam int          ENTRY_W           = ptmi_pkg::ENTRY_W;
    localparam int          PA_W              = ptmi_pkg::PA_W;
    localparam int          VA_W              = ptmi_pkg::VA_W;
    localparam int          FLAG_W            = ptmi_pkg::FLAG_W;
    localparam int          PAGE_SHIFT        = ptmi_pkg::PAGE_SHIFT;
    localparam int          STORE_DEPTH  = TABLE_COUNT * ENTRIES_PER_TABLE;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam logic [3:0]  ADDR_ROOT_TABLE = {ptmi_pkg::REG_ROOT_TABLE, 3'b000};
    localparam logic [3:0]  ADDR_POOL_BASE  = {ptmi_pkg::REG_POOL_BASE, 3'b000};

    // One result word as the block reports it
    typedef struct packed {
        logic               status;
        logic [1:0]         added;
        logic [ENTRY_W-1:0] leaf;
    } t_map_result;

    // Mirrors the table store and bump allocator; holds the expected result words
    class t_walk_scoreboard;
        bit [ENTRY_W-1:0] pte_store [STORE_DEPTH];
        int unsigned      next_free;
        bit [1:0]         root_sel;
        bit [PA_W-1:0]    pool_base;
        t_map_result      expected_q[$];
        int unsigned      mismatches;
        int unsigned      results_seen;

        function new();
            next_free    = ROOT_TABLES;
            root_sel     = '0;
            pool_base    = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [3:0] addr, logic [63:0] data);
            if (addr == ADDR_ROOT_TABLE) begin
                root_sel = data[1:0];
            end else if (addr == ADDR_POOL_BASE) begin
                pool_base = data[PA_W-1:0];
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Walk the mirrored tables for one accepted word and queue its result
        function void note_request(bit [VA_W-1:0] va, bit [PA_W-1:0] pa, bit [FLAG_W-1:0] fl);
            t_map_result      res;
            int unsigned      cur;
            int unsigned      ix;
            int unsigned      slot;
            int unsigned      lvl;
            int unsigned      i;
            bit               failed;
            bit [ENTRY_W-1:0] ent;
            bit [PA_W-1:0]    base_pg;
            bit [PA_W-1:0]    off;

            base_pg    = {pool_base[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            cur        = (root_sel >= ROOT_TABLES) ? ROOT_TABLES - 1 : root_sel;
            res.status = ptmi_pkg::STATUS_OK;
            res.added  = '0;
            res.leaf   = '0;
            failed     = 1'b0;

            for (lvl = 0; lvl < 3; lvl++) begin
                if (!failed) begin
                    ix   = 32'(va >> (39 - 9 * lvl)) & 32'h1ff;
                    slot = cur * ENTRIES_PER_TABLE + ix;
                    ent  = pte_store[slot];
                    // absent entry: take a fresh cleared table, unless the pool is spent
                    if (!ent[0]) begin
                        if (next_free >= TABLE_COUNT) begin
                            failed = 1'b1;
                        end else begin
                            for (i = 0; i < ENTRIES_PER_TABLE; i++)
                                pte_store[next_free * ENTRIES_PER_TABLE + i] = '0;
                            ent = {{(ENTRY_W-PA_W){1'b0}},
                                   base_pg + (PA_W'(next_free) << PAGE_SHIFT)} | ENTRY_W'(fl);
                            pte_store[slot] = ent;
                            next_free++;
                            res.added++;
                        end
                    end
                    // follow the pointer; anything outside the pool is a stray pointer
                    if (!failed) begin
                        off = {ent[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} - base_pg;
                        if (off[PA_W-1:PAGE_SHIFT] >= TABLE_COUNT)
                            failed = 1'b1;
                        else
                            cur = 32'(off[PA_W-1:PAGE_SHIFT]);
                    end
                end
            end

            if (failed) begin
                res.status = ptmi_pkg::STATUS_ERROR;
            end else begin
                res.leaf = {{(ENTRY_W-PA_W){1'b0}}, pa} | ENTRY_W'(fl);
                pte_store[cur * ENTRIES_PER_TABLE + va[20:12]] = res.leaf;
            end
            expected_q.push_back(res);
        endfunction

        // Print one line per mismatch and count it
        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] MISMATCH word %0d: %s", $realtime, results_seen, what);
        endtask

        task check_result(logic st, logic [1:0] added, logic [ENTRY_W-1:0] leaf);
            t_map_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("result word with no request outstanding");
            end else begin
                want = expected_q.pop_front();
                if (st !== want.status)
                    report_mismatch($sformatf("status %0b, want %0b", st, want.status));
                if (added !== want.added)
                    report_mismatch($sformatf("tables_added %0d, want %0d", added, want.added));
                if (leaf !== want.leaf)
                    report_mismatch($sformatf("leaf_value %h, want %h", leaf, want.leaf));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [VA_W-1:0]     i_va;
    logic [PA_W-1:0]     i_pa;
    logic [FLAG_W-1:0]   i_flags;
    logic                o_done;
    logic                o_status;
    logic [1:0]          o_tables_added;
    logic [ENTRY_W-1:0]  o_leaf_value;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [63:0]         pwdata;
    logic [63:0]         prdata;
    logic                pready;

    t_walk_scoreboard    sb;
    int unsigned         cycle_count;
    bit [26:0]           hot_prefix [4];

    page_table_map_insert uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_va           (i_va),
        .i_pa           (i_pa),
        .i_flags        (i_flags),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_tables_added (o_tables_added),
        .o_leaf_value   (o_leaf_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop if the run hangs
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Check every result word on the edge that ends its strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1)
            sb.check_result(o_status, o_tables_added, o_leaf_value);
    end

    // Present one map word and hold it until the block takes it
    task automatic issue_map(bit [VA_W-1:0] va, bit [PA_W-1:0] pa, bit [FLAG_W-1:0] fl);
        @(negedge i_clk);
        start   <= 1'b1;
        i_va    <= va;
        i_pa    <= pa;
        i_flags <= fl;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(va, pa, fl);
    endtask

    // Drop start for the idle gap given by n
    task automatic idle_gap(int unsigned n);
        if (n != 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Drop start and wait for every outstanding result word
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0 || busy !== 1'b0) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic apb_write(logic [3:0] addr, logic [63:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_register(addr, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random words: mostly reuse of a few hot paths so walks reach the leaf
    task automatic random_phase(int unsigned n_words);
        bit [VA_W-1:0]   va;
        bit [PA_W-1:0]   pa;
        bit [FLAG_W-1:0] fl;
        int unsigned     kind;
        int unsigned     burst_left;
        int unsigned     k;

        burst_left = 0;
        for (k = 0; k < n_words; k++) begin
            kind = $urandom_range(0, 99);
            va   = VA_W'({$urandom, $urandom});
            if (kind < 65)
                va[47:21] = hot_prefix[$urandom_range(0, 3)];
            else if (kind < 80)
                va[47:30] = hot_prefix[$urandom_range(0, 3)][26:9];

            kind = $urandom_range(0, 19);
            if (kind == 0)
                pa = '0;
            else if (kind == 1)
                pa = '1;
            else
                pa = PA_W'({$urandom, $urandom});

            fl = FLAG_W'($urandom_range(0, 4095));
            fl[0] = ($urandom_range(0, 9) != 0);

            issue_map(va, pa, fl);

            if (burst_left == 0 && $urandom_range(0, 19) == 0)
                burst_left = $urandom_range(10, 40);
            if (burst_left != 0)
                burst_left--;
            else
                idle_gap(pick_gap());
        end
    endtask

    // Extremes, flags without present bit, partial path reuse, wrap and stray pointers
    task automatic directed_part();
        apb_write(ADDR_ROOT_TABLE, 64'd0);
        apb_write(ADDR_POOL_BASE, 64'd0);
        issue_map('0, '0, 12'h001);
        issue_map('0, '1, 12'hFFF);
        issue_map('1, '1, 12'hFFF);
        issue_map(48'h0000_0000_1ABC, 52'h1_2345_6789_A000, 12'h003);
        // no present bit: the same path allocates again next time
        issue_map(48'h0080_0000_0000, 52'hA_0000_0000_0000, 12'h000);
        issue_map(48'h0080_0000_0000, 52'h5_5555_5555_5000, 12'h001);
        idle_gap(3);
        issue_map(48'h0000_4000_0000, 52'h0_0000_0000_1000, 12'h801);
        issue_map(48'h0000_0020_0000, 52'hF_0F0F_0F0F_0F0F, 12'h7FF);
        issue_map(48'hFFFF_FFFF_E000, 52'h0_FFFF_0000_F000, 12'hAA5);
        drain();

        // top root, pool base at the very top so table addresses wrap
        apb_write(ADDR_ROOT_TABLE, '1);
        apb_write(ADDR_POOL_BASE, '1);
        issue_map('0, 52'h3_3333_3333_3000, 12'h001);
        issue_map(48'h8000_0000_0000, 52'hC_CCCC_CCCC_C000, 12'h555);
        drain();

        // move the pool away: old pointers in both roots now stray
        apb_write(ADDR_ROOT_TABLE, 64'd0);
        apb_write(ADDR_POOL_BASE, 64'h0008_0000_0000_0ABC);
        issue_map('0, 52'h1_0000_0000_0000, 12'h001);
        drain();
        apb_write(ADDR_ROOT_TABLE, 64'hFFFF_0000_0000_0003);
        issue_map('0, 52'h2_0000_0000_0000, 12'h001);
        drain();
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_va        = '0;
        i_pa        = '0;
        i_flags     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        foreach (hot_prefix[j])
            hot_prefix[j] = 27'($urandom);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_part();

        // root 1 on a zero base
        apb_write(ADDR_ROOT_TABLE, {$urandom, $urandom} & ~64'h2 | 64'h1);
        apb_write(ADDR_POOL_BASE, 64'd0);
        random_phase(250);
        drain();

        // back to root 0 with the directed paths in place
        apb_write(ADDR_ROOT_TABLE, 64'd0);
        apb_write(ADDR_POOL_BASE, {12'h000, 52'd0} | {$urandom, 20'h0, 12'h000} >> 52);
        random_phase(150);
        drain();

        // root 2 on a random base
        apb_write(ADDR_ROOT_TABLE, 64'd2);
        apb_write(ADDR_POOL_BASE, {$urandom, $urandom});
        random_phase(100);
        drain();

        // root 1 with the base shifted by a few tables: pointers alias or stray
        apb_write(ADDR_ROOT_TABLE, 64'd1);
        apb_write(ADDR_POOL_BASE, 64'h0000_0000_0000_3000);
        random_phase(100);
        drain();

        // restore root 1 on a zero base
        apb_write(ADDR_POOL_BASE, 64'd0);
        random_phase(200);
        drain();

        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
